@@ rtl/bpnm_pkg.sv @@
// shared types, constants and arithmetic helpers for the blend palette match block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bpnm_pkg;

    localparam int PALETTE_SIZE = 256;   // entries searched, 2 to 256
    localparam int STORE_DEPTH  = 256;   // stores are always full depth
    localparam int IDX_W        = 8;
    localparam int COLOR_W      = 8;
    localparam int SUM_W        = 16;
    localparam int SQ_W         = 16;
    localparam int DIST_W       = 20;
    localparam int QUEUE_DEPTH  = 2;     // power of two
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(PALETTE_SIZE - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO   = '0;
    localparam logic [IDX_W-1:0] IDX_MAX    = '1;

    typedef enum logic [1:0] {
        OP_WR_FG   = 2'd0,
        OP_WR_BG   = 2'd1,
        OP_WR_MASK = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_WR_FG,
        KIND_WR_BG,
        KIND_WR_MASK,
        KIND_FIXED,
        KIND_SCAN
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
        logic               allowed_bit;
        logic [IDX_W-1:0]   fg_index;
        logic [IDX_W-1:0]   bg_index;
        logic [IDX_W-1:0]   fixed_index;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BLEND,
        ST_SCAN,
        ST_RESULT
    } back_state_t;

    // bg*(255-a) + fg*a, at most 65025
    function automatic logic [SUM_W-1:0] mix(input logic [COLOR_W-1:0] bgc,
                                             input logic [COLOR_W-1:0] fgc,
                                             input logic [COLOR_W-1:0] a);
        logic [SUM_W-1:0] p0;
        logic [SUM_W-1:0] p1;
        p0 = SUM_W'({8'd0, bgc} * {8'd0, ~a});
        p1 = SUM_W'({8'd0, fgc} * {8'd0, a});
        return p0 + p1;
    endfunction

    // exact floor(x / 255) for x up to 65025, the largest sum that mix returns
    function automatic logic [COLOR_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + (SUM_W + 1)'(x[SUM_W-1:8]) + (SUM_W + 1)'(1);
        return COLOR_W'(t >> 8);
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] x,
                                                input logic [COLOR_W-1:0] y);
        logic [COLOR_W-1:0] d;
        d = (x > y) ? (x - y) : (y - x);
        return SQ_W'({8'd0, d} * {8'd0, d});
    endfunction

endpackage

@@ rtl/bpnm_front.sv @@
// front end: input register slice that decodes each word into a queue item
// uses bpnm_pkg; feeds bpnm_queue
`timescale 1ns / 1ps

module bpnm_front import bpnm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [COLOR_W-1:0] s_red,
    input  logic [COLOR_W-1:0] s_green,
    input  logic [COLOR_W-1:0] s_blue,
    input  logic [COLOR_W-1:0] s_alpha,
    input  logic               s_allowed_bit,
    input  logic [IDX_W-1:0]   s_fg_index,
    input  logic [IDX_W-1:0]   s_bg_index,
    output logic               push_valid,
    output item_t              push_item,
    input  logic               q_full
);

    logic  hold_valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_ready    = !hold_valid_reg || !q_full;
    assign push_valid = hold_valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_next.entry_index = s_entry_index;
        item_next.red         = s_red;
        item_next.green       = s_green;
        item_next.blue        = s_blue;
        item_next.alpha       = s_alpha;
        item_next.allowed_bit = s_allowed_bit;
        item_next.fg_index    = s_fg_index;
        item_next.bg_index    = s_bg_index;
        item_next.fixed_index = IDX_ZERO;
        item_next.kind        = KIND_SCAN;
        case (op_t'(s_op))
            OP_WR_FG:   item_next.kind = KIND_WR_FG;
            OP_WR_BG:   item_next.kind = KIND_WR_BG;
            OP_WR_MASK: item_next.kind = KIND_WR_MASK;
            OP_LOOKUP: begin
                // transparent foreground wins over the reserved index
                if (s_fg_index == IDX_ZERO) begin
                    item_next.kind        = KIND_FIXED;
                    item_next.fixed_index = s_bg_index;
                end else if (s_fg_index == IDX_MAX || s_bg_index == IDX_MAX) begin
                    item_next.kind        = KIND_FIXED;
                end else begin
                    item_next.kind        = KIND_SCAN;
                end
            end
            default:    item_next.kind = KIND_SCAN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/bpnm_queue.sv @@
// short fifo of decoded items between front and back
// uses bpnm_pkg
`timescale 1ns / 1ps

module bpnm_queue import bpnm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  q_full,
    input  logic  q_pop,
    output logic  q_empty,
    output item_t q_head
);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign push    = push_valid && !q_full;
    assign q_head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (!push && q_pop) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/bpnm_back.sv @@
// back end: palette stores, blend, nearest-match scan and output register
// uses bpnm_pkg; drains bpnm_queue
`timescale 1ns / 1ps

module bpnm_back import bpnm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  item_t              q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [IDX_W-1:0]   m_match_index,
    output logic [DIST_W-1:0]  m_match_distance
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [4*COLOR_W-1:0] fg_mem [STORE_DEPTH];
    logic [3*COLOR_W-1:0] bg_mem [STORE_DEPTH];
    logic [4*COLOR_W-1:0] fg_rdata_reg;
    logic [3*COLOR_W-1:0] bg_rdata_reg;
    logic [IDX_W-1:0]     bg_addr;
    logic [STORE_DEPTH-1:0] mask_reg;

    logic [SUM_W-1:0]   sum_r_reg, sum_g_reg, sum_b_reg;
    logic [COLOR_W-1:0] col_r_reg, col_g_reg, col_b_reg;

    logic               iss_active_reg;
    logic [IDX_W-1:0]   iss_addr_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_tag_reg;
    logic               dist_vld_reg;
    logic [IDX_W-1:0]   dist_tag_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [DIST_W-1:0]  dist_next;
    logic               dist_last;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;

    logic               out_free;
    logic               fixed_load;
    logic               result_load;
    logic               m_valid_reg;
    logic [IDX_W-1:0]   m_match_index_reg;
    logic [DIST_W-1:0]  m_match_distance_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign dist_last = (dist_tag_reg == LAST_ENTRY);
    assign bg_addr   = (state_reg == ST_IDLE) ? q_head.bg_index : iss_addr_reg;

    // control
    always_comb begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        fixed_load  = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    case (q_head.kind)
                        KIND_FIXED: begin
                            if (out_free) begin
                                q_pop      = 1'b1;
                                fixed_load = 1'b1;
                            end
                        end
                        KIND_SCAN: begin
                            q_pop      = 1'b1;
                            state_next = ST_READ;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            ST_READ:  state_next = ST_BLEND;
            ST_BLEND: state_next = ST_SCAN;
            ST_SCAN: begin
                if (dist_vld_reg && dist_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // palette stores
    always_ff @(posedge aclk) begin
        if (q_pop && q_head.kind == KIND_WR_FG) begin
            fg_mem[q_head.entry_index] <= {q_head.alpha, q_head.blue, q_head.green, q_head.red};
        end
        fg_rdata_reg <= fg_mem[q_head.fg_index];
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_head.kind == KIND_WR_BG) begin
            bg_mem[q_head.entry_index] <= {q_head.blue, q_head.green, q_head.red};
        end
        bg_rdata_reg <= bg_mem[bg_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (q_pop && q_head.kind == KIND_WR_MASK) begin
            mask_reg[q_head.entry_index] <= q_head.allowed_bit;
        end
    end

    // blend: products, then divide by 255
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            sum_r_reg <= mix(bg_rdata_reg[7:0],   fg_rdata_reg[7:0],   fg_rdata_reg[31:24]);
            sum_g_reg <= mix(bg_rdata_reg[15:8],  fg_rdata_reg[15:8],  fg_rdata_reg[31:24]);
            sum_b_reg <= mix(bg_rdata_reg[23:16], fg_rdata_reg[23:16], fg_rdata_reg[31:24]);
        end
        if (state_reg == ST_BLEND) begin
            col_r_reg <= div255(sum_r_reg);
            col_g_reg <= div255(sum_g_reg);
            col_b_reg <= div255(sum_b_reg);
        end
    end

    // scan: issue address, read, distance, compare
    always_comb begin
        dist_next = DIST_W'(3) * DIST_W'(sq_diff(col_r_reg, bg_rdata_reg[7:0]))
                  + DIST_W'(6) * DIST_W'(sq_diff(col_g_reg, bg_rdata_reg[15:8]))
                  + DIST_W'(sq_diff(col_b_reg, bg_rdata_reg[23:16]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_active_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            dist_vld_reg   <= 1'b0;
        end else begin
            if (state_reg == ST_BLEND) begin
                iss_active_reg <= 1'b1;
            end else if (iss_active_reg && iss_addr_reg == LAST_ENTRY) begin
                iss_active_reg <= 1'b0;
            end
            rd_vld_reg   <= iss_active_reg;
            dist_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_BLEND) begin
            iss_addr_reg <= IDX_ZERO;
        end else if (iss_active_reg) begin
            iss_addr_reg <= iss_addr_reg + IDX_W'(1);
        end
        rd_tag_reg   <= iss_addr_reg;
        dist_reg     <= dist_next;
        dist_tag_reg <= rd_tag_reg;
        // entry zero seeds the best match whether allowed or not
        if (dist_vld_reg) begin
            if (dist_tag_reg == IDX_ZERO ||
                (mask_reg[dist_tag_reg] && dist_reg < best_dist_reg)) begin
                best_idx_reg  <= dist_tag_reg;
                best_dist_reg <= dist_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fixed_load || result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fixed_load) begin
            m_match_index_reg    <= q_head.fixed_index;
            m_match_distance_reg <= '0;
        end else if (result_load) begin
            m_match_index_reg    <= best_idx_reg;
            m_match_distance_reg <= best_dist_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_match_index    = m_match_index_reg;
    assign m_match_distance = m_match_distance_reg;

endmodule

@@ rtl/blend_palette_nearest_match.sv @@
// top level of the blend palette nearest match block
// uses bpnm_pkg; instantiates bpnm_front, bpnm_queue and bpnm_back
//
//   channel   direction  ports
//   s_        in         op, entry_index, red, green, blue, alpha, allowed_bit, fg_index, bg_index
//   m_        out        match_index, match_distance (one word per lookup only)
//
// store writes are taken from the idle state of the back end; fixed-case lookups too, once the output is free
// a searched lookup runs a one-entry-per-cycle scan through the single read port of the
// background palette, then waits in its result state until the output register is free
// the front and its two-entry queue keep taking words while the back end scans, until the queue fills
// synchronous active-low reset clears control state and the allowed mask
`timescale 1ns / 1ps

module blend_palette_nearest_match import bpnm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [COLOR_W-1:0] s_red,
    input  logic [COLOR_W-1:0] s_green,
    input  logic [COLOR_W-1:0] s_blue,
    input  logic [COLOR_W-1:0] s_alpha,
    input  logic               s_allowed_bit,
    input  logic [IDX_W-1:0]   s_fg_index,
    input  logic [IDX_W-1:0]   s_bg_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [IDX_W-1:0]   m_match_index,
    output logic [DIST_W-1:0]  m_match_distance
);

    logic  push_valid;
    item_t push_item;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_head;

    bpnm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_entry_index (s_entry_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_alpha       (s_alpha),
        .s_allowed_bit (s_allowed_bit),
        .s_fg_index    (s_fg_index),
        .s_bg_index    (s_bg_index),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .q_full        (q_full)
    );

    bpnm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .q_full     (q_full),
        .q_pop      (q_pop),
        .q_empty    (q_empty),
        .q_head     (q_head)
    );

    bpnm_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_index    (m_match_index),
        .m_match_distance (m_match_distance)
    );

endmodule

@@ tb/blend_palette_nearest_match_test.sv @@
// testbench for blend_palette_nearest_match: palette and mask loads, fixed and searched lookups
// depends on rtl/bpnm_pkg.sv and the block's rtl; a scoreboard class predicts every match word
`timescale 1ns / 1ps

import bpnm_pkg::*;

typedef struct {
    op_t        op;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       allowed_bit;
    logic [7:0] fg_index;
    logic [7:0] bg_index;
} palette_word_t;

typedef struct {
    logic [7:0]  index;
    logic [19:0] distance;
} match_t;

class blend_match_board;
    bit [31:0] fg_color [256];
    bit [23:0] bg_color [256];
    bit        allowed [256];
    match_t    expected_matches [$];
    int        errors;
    int        checked_words;
    int        palette_writes;
    int        mask_writes;
    int        fixed_lookups;
    int        searched_lookups;

    function int unsigned weighted_distance(bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                            bit [23:0] entry);
        int dr;
        int dg;
        int db;
        dr = int'(r) - int'(entry[7:0]);
        dg = int'(g) - int'(entry[15:8]);
        db = int'(b) - int'(entry[23:16]);
        return 3 * dr * dr + 6 * dg * dg + db * db;
    endfunction

    function bit [7:0] blend_channel(bit [7:0] bgc, bit [7:0] fgc, bit [7:0] a);
        int unsigned mixed;
        mixed = int'(bgc) * (255 - int'(a)) + int'(fgc) * int'(a);
        return 8'(mixed / 255);
    endfunction

    function match_t predict_match(bit [7:0] fi, bit [7:0] bi);
        match_t      m;
        bit [31:0]   fe;
        bit [23:0]   be;
        bit [7:0]    r;
        bit [7:0]    g;
        bit [7:0]    b;
        int unsigned d;
        int unsigned best_d;
        fe = fg_color[fi];
        be = bg_color[bi];
        r = blend_channel(be[7:0], fe[7:0], fe[31:24]);
        g = blend_channel(be[15:8], fe[15:8], fe[31:24]);
        b = blend_channel(be[23:16], fe[23:16], fe[31:24]);
        m.index = '0;
        best_d = weighted_distance(r, g, b, bg_color[0]);
        for (int k = 0; k < PALETTE_SIZE; k++) begin
            if (allowed[k]) begin
                d = weighted_distance(r, g, b, bg_color[k]);
                if (d < best_d) begin
                    best_d = d;
                    m.index = 8'(k);
                end
            end
        end
        m.distance = 20'(best_d);
        return m;
    endfunction

    function void note_word(palette_word_t w);
        match_t m;
        case (w.op)
            OP_WR_FG: begin
                fg_color[w.entry_index] = {w.alpha, w.blue, w.green, w.red};
                palette_writes++;
            end
            OP_WR_BG: begin
                bg_color[w.entry_index] = {w.blue, w.green, w.red};
                palette_writes++;
            end
            OP_WR_MASK: begin
                allowed[w.entry_index] = w.allowed_bit;
                mask_writes++;
            end
            default: begin
                if (w.fg_index == IDX_ZERO) begin
                    m.index = w.bg_index;
                    m.distance = '0;
                    fixed_lookups++;
                end else if (w.fg_index == IDX_MAX || w.bg_index == IDX_MAX) begin
                    m.index = '0;
                    m.distance = '0;
                    fixed_lookups++;
                end else begin
                    m = predict_match(w.fg_index, w.bg_index);
                    searched_lookups++;
                end
                expected_matches.push_back(m);
            end
        endcase
    endfunction

    function void check_word(logic [7:0] index, logic [19:0] distance);
        match_t m;
        checked_words++;
        if (expected_matches.size() == 0) begin
            $display("%0t: unexpected word, index %0d distance %0d", $time, index, distance);
            errors++;
            return;
        end
        m = expected_matches.pop_front();
        if (index !== m.index) begin
            $display("%0t: match_index expected %0d got %0d", $time, m.index, index);
            errors++;
        end
        if (distance !== m.distance) begin
            $display("%0t: match_distance expected %0d got %0d", $time, m.distance, distance);
            errors++;
        end
    endfunction
endclass

module blend_palette_nearest_match_test;

    localparam int RANDOM_WORDS = 570;
    localparam int HOLD_CYCLES  = 600;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = '0;
    logic [7:0] s_entry_index = '0;
    logic [7:0] s_red = '0;
    logic [7:0] s_green = '0;
    logic [7:0] s_blue = '0;
    logic [7:0] s_alpha = '0;
    logic       s_allowed_bit = 1'b0;
    logic [7:0] s_fg_index = '0;
    logic [7:0] s_bg_index = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_match_index;
    logic [19:0] m_match_distance;

    blend_match_board board;
    bit       steady = 1'b0;
    bit       fg_written [256];
    int       fg_lookup_list [$];

    blend_palette_nearest_match dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_entry_index    (s_entry_index),
        .s_red            (s_red),
        .s_green          (s_green),
        .s_blue           (s_blue),
        .s_alpha          (s_alpha),
        .s_allowed_bit    (s_allowed_bit),
        .s_fg_index       (s_fg_index),
        .s_bg_index       (s_bg_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_index    (m_match_index),
        .m_match_distance (m_match_distance)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 31);
    endfunction

    function automatic palette_word_t make_word(op_t op, logic [7:0] idx, logic [7:0] r,
                                                logic [7:0] g, logic [7:0] b, logic [7:0] a,
                                                logic bit_v, logic [7:0] fi, logic [7:0] bi);
        palette_word_t w;
        w.op = op;
        w.entry_index = idx;
        w.red = r;
        w.green = g;
        w.blue = b;
        w.alpha = a;
        w.allowed_bit = bit_v;
        w.fg_index = fi;
        w.bg_index = bi;
        return w;
    endfunction

    task automatic send_word(palette_word_t w);
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= w.op;
        s_entry_index <= w.entry_index;
        s_red <= w.red;
        s_green <= w.green;
        s_blue <= w.blue;
        s_alpha <= w.alpha;
        s_allowed_bit <= w.allowed_bit;
        s_fg_index <= w.fg_index;
        s_bg_index <= w.bg_index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
        // fg entries that a searched lookup may read
        if (w.op == OP_WR_FG && w.entry_index != IDX_ZERO && w.entry_index != IDX_MAX
                && !fg_written[w.entry_index]) begin
            fg_written[w.entry_index] = 1'b1;
            fg_lookup_list.push_back(int'(w.entry_index));
        end
    endtask

    // receiver: checks accepted words, idles at random, one long hold-off
    initial begin : drain
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                board.check_word(m_match_index, m_match_distance);
                if (!hold_done && board.checked_words == 40) begin
                    hold_done = 1'b1;
                    stall_left = HOLD_CYCLES;
                end
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    initial begin : stimulus
        palette_word_t w;
        int pick;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // searches read every bg entry, so load them all first
        for (int i = 0; i < 256; i++)
            send_word(make_word(OP_WR_BG, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));

        // empty mask, opaque white foreground: entry 0, black, at the largest distance
        send_word(make_word(OP_WR_BG, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9, 1'b1, 8'd4, 8'd4));
        send_word(make_word(OP_WR_FG, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0,
                            8'd0, 8'd0));
        send_word(make_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd1, 8'd1));
        // fixed cases
        send_word(make_word(OP_LOOKUP, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
                            8'd0, 8'd255));
        send_word(make_word(OP_LOOKUP, 8'd3, 8'd1, 8'd2, 8'd3, 8'd4, 1'b0, 8'd0, 8'd7));
        send_word(make_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd255, 8'd3));
        send_word(make_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd5, 8'd255));
        // mask edges, set and cleared
        send_word(make_word(OP_WR_MASK, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
        send_word(make_word(OP_WR_MASK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
        send_word(make_word(OP_WR_MASK, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
        send_word(make_word(OP_WR_MASK, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
        // equal entries: the lower index wins
        send_word(make_word(OP_WR_BG, 8'd10, 8'd17, 8'd99, 8'd200, 8'd0, 1'b0, 8'd0, 8'd0));
        send_word(make_word(OP_WR_BG, 8'd20, 8'd17, 8'd99, 8'd200, 8'd0, 1'b0, 8'd0, 8'd0));
        send_word(make_word(OP_WR_MASK, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
        send_word(make_word(OP_WR_MASK, 8'd20, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0));
        send_word(make_word(OP_WR_FG, 8'd3, 8'd250, 8'd5, 8'd128, 8'd0, 1'b0, 8'd0, 8'd0));
        send_word(make_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd3, 8'd20));
        // half blend and opaque foreground against the top entries
        send_word(make_word(OP_WR_FG, 8'd254, 8'd200, 8'd40, 8'd0, 8'd128, 1'b0, 8'd0, 8'd0));
        send_word(make_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd254, 8'd254));
        send_word(make_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd1, 8'd254));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 250 && n < 400);
            w = make_word(OP_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                w.op = OP_WR_FG;
            end else if (pick < 25) begin
                w.op = OP_WR_BG;
            end else if (pick < 40) begin
                w.op = OP_WR_MASK;
                w.allowed_bit = ($urandom_range(0, 99) < 70);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    w.fg_index = IDX_ZERO;
                else if (pick < 15)
                    w.fg_index = IDX_MAX;
                else
                    w.fg_index = 8'(fg_lookup_list[$urandom_range(0,
                                                   fg_lookup_list.size() - 1)]);
                if ($urandom_range(0, 99) < 6)
                    w.bg_index = IDX_MAX;
            end
            send_word(w);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (board.expected_matches.size() != 0) @(posedge aclk);
        repeat (PALETTE_SIZE + 20) @(posedge aclk);

        $display("covered %0d palette writes, %0d mask writes, %0d fixed and %0d searched lookups",
                 board.palette_writes, board.mask_writes, board.fixed_lookups,
                 board.searched_lookups);
        $display("%0d result words checked, %0d mismatches", board.checked_words, board.errors);
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bpnm_pkg.sv
rtl/bpnm_front.sv
rtl/bpnm_queue.sv
rtl/bpnm_back.sv
rtl/blend_palette_nearest_match.sv
tb/blend_palette_nearest_match_test.sv
